// ----- hdl/hof_pkg.sv -----
`default_nettype none

package hof_pkg;

   localparam int WINDOW         = 7;
   localparam int SAMPLE_BITS    = 16;
   localparam int KEY_BITS       = SAMPLE_BITS + 1;
   localparam int CNT_BITS       = $clog2(WINDOW + 1);
   // one sort pass: feed all WINDOW values, then let the middle cell settle
   localparam int SORT_STEPS     = WINDOW + WINDOW / 2;
   localparam int STEP_BITS      = $clog2(SORT_STEPS);
   localparam int CFG_BITS       = 16;
   localparam int BASE_BITS      = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
   localparam int PROD_BITS      = CFG_BITS + BASE_BITS;
   localparam int TDATA_BITS     = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT_SCALE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAD_FLOOR   = CSR_INDEX_BITS'(1);

   localparam logic [CFG_BITS-1:0] LIMIT_SCALE_RESET = CFG_BITS'(1898);
   localparam logic [CFG_BITS-1:0] MAD_FLOOR_RESET   = CFG_BITS'(1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [KEY_BITS-1:0]    key_type;

   // one value travelling down the sort cell row
   typedef struct packed {
      logic    valid;
      key_type key;
   } sort_link_type;

endpackage

`default_nettype wire

// ----- hdl/hof_sort_cell.sv -----
`default_nettype none

module hof_sort_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  clear,
   input  wire hof_pkg::sort_link_type link_in,
   output hof_pkg::sort_link_type      link_out,
   output hof_pkg::key_type            key
);
   import hof_pkg::*;

   key_type key_ff, key_in;
   logic    held_ff, held_in;
   logic    out_valid_ff, out_valid_in;
   key_type out_key_ff, out_key_in;
   logic    take;

   // keep the smaller key, hand the larger one to the neighbor next cycle
   always_comb begin
      take          = link_in.valid && (!held_ff || (link_in.key < key_ff));
      out_valid_in  = !clear && link_in.valid && held_ff;
      out_key_in    = take ? key_ff : link_in.key;
      key_in        = take ? link_in.key : key_ff;
      held_in       = clear ? 1'b0 : (held_ff || link_in.valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      out_key_ff <= out_key_in;
   end

   assign link_out = {out_valid_ff, out_key_ff};
   assign key      = key_ff;

endmodule

`default_nettype wire

// ----- hdl/hof_window_line.sv -----
`default_nettype none

module hof_window_line (
   input  wire logic                clock,
   input  wire logic                shift_en,
   input  wire logic                rotate_en,
   input  wire hof_pkg::sample_type sample_in,
   output hof_pkg::sample_type      tail
);
   import hof_pkg::*;

   sample_type cells_ff [WINDOW];
   sample_type cells_in [WINDOW];

   // newest sample enters cell 0; WINDOW rotations bring the window back
   // to its original order
   always_comb begin
      for (int i = 1; i < WINDOW; i++) begin
         cells_in[i] = (shift_en || rotate_en) ? cells_ff[i-1] : cells_ff[i];
      end
      if (shift_en) begin
         cells_in[0] = sample_in;
      end else if (rotate_en) begin
         cells_in[0] = cells_ff[WINDOW-1];
      end else begin
         cells_in[0] = cells_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
   end

   assign tail = cells_ff[WINDOW-1];

endmodule

`default_nettype wire

// ----- hdl/hampel_outlier_filter_unit.sv -----
`default_nettype none

// Channel | Dir | Ports                         | Contents (low bit first)
// req     | in  | req_tvalid/tready/tdata        | tdata: sample
// rsp     | out | rsp_tvalid/tready/tdata/tuser  | tdata: filtered; tuser: replaced, window_full
// csr     | in  | csr_valid/ready/index/data     | index 0 limit_scale, 1 mad_floor
//
// Sequence: once the window is full, each sample takes two sort passes (values,
//   then deviations from the median); each feeds WINDOW values, one a cycle, then
//   waits for the middle cell to settle. While the window fills, samples pass through.
// Reset: synchronous; clears control, fill count and config, not the window.
// Stalls: a result waits in the output register; the next sample transfer is
//   still taken, and its result holds in the emit state until the register is free.

module hampel_outlier_filter_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // stream in
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [hof_pkg::TDATA_BITS-1:0]      req_tdata,   // [15:0] sample
   // stream out
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [hof_pkg::TDATA_BITS-1:0]           rsp_tdata,   // [15:0] filtered
   output logic [1:0]                               rsp_tuser,   // [0] replaced, [1] window_full
   // register writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [hof_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [hof_pkg::CFG_BITS-1:0]        csr_data
);
   import hof_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SORT_VAL = 3'd1;
   localparam logic [2:0] S_TAKE_MED = 3'd2;
   localparam logic [2:0] S_SORT_DEV = 3'd3;
   localparam logic [2:0] S_TAKE_MAD = 3'd4;
   localparam logic [2:0] S_PRODUCT  = 3'd5;
   localparam logic [2:0] S_EMIT     = 3'd6;

   // |a - b|, exact at one extra bit
   function automatic logic [SAMPLE_BITS-1:0] abs_diff(sample_type a, sample_type b);
      logic signed [SAMPLE_BITS:0] d;
      logic signed [SAMPLE_BITS:0] m;
      d = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
      m = d[SAMPLE_BITS] ? -d : d;
      return m[SAMPLE_BITS-1:0];
   endfunction

   logic [2:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]  fill_ff, fill_in;
   logic                pass_ff, pass_in;          // filling: sample goes straight out
   sample_type          x_ff, x_in;
   sample_type          med_ff, med_in;
   logic [SAMPLE_BITS-1:0] dev_ff, dev_in;
   logic [BASE_BITS-1:0]   base_ff, base_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [CFG_BITS-1:0]    scale_ff, scale_in;
   logic [CFG_BITS-1:0]    floor_ff, floor_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_filtered_ff, rsp_filtered_in;
   logic                   rsp_replaced_ff, rsp_replaced_in;
   logic                   rsp_full_ff, rsp_full_in;

   logic          req_xfer;
   logic          csr_xfer;
   logic          out_free;
   sample_type    sample;
   sample_type    tail;
   logic          sorting;
   logic          feeding;
   logic          sort_clear;
   sort_link_type link [WINDOW];
   key_type       cell_key [WINDOW];
   key_type       mid_key;
   logic [SAMPLE_BITS-1:0]  mad_val;
   logic [SAMPLE_BITS+7:0]  lhs;
   logic                    outlier;

   assign sample     = sample_type'(req_tdata[SAMPLE_BITS-1:0]);
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_xfer   = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // a pass feeds WINDOW values, then lets the row settle
   assign sorting    = (state_ff == S_SORT_VAL) || (state_ff == S_SORT_DEV);
   assign feeding    = sorting && (cnt_ff < STEP_BITS'(WINDOW));
   assign sort_clear = (state_ff == S_IDLE) || (state_ff == S_TAKE_MED);

   // window line: shifts on a sample transfer, rotates while feeding
   hof_window_line u_window (
      .clock     (clock),
      .shift_en  (req_xfer),
      .rotate_en (feeding),
      .sample_in (sample),
      .tail      (tail)
   );

   // feed: raw samples on the first pass, deviations from median on the second
   always_comb begin
      link[0].valid = feeding;
      if (state_ff == S_SORT_DEV) begin
         link[0].key = key_type'({1'b0, abs_diff(tail, med_ff)});
      end else begin
         link[0].key = key_type'(tail);
      end
   end

   // insertion sort row: cell 0 ends up with the smallest key
   for (genvar i = 0; i < WINDOW; i++) begin : g_sort
      if (i == WINDOW - 1) begin : g_last
         hof_sort_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .clear    (sort_clear),
            .link_in  (link[i]),
            .link_out (),
            .key      (cell_key[i])
         );
      end else begin : g_mid
         hof_sort_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .clear    (sort_clear),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .key      (cell_key[i])
         );
      end
   end

   // middle of the sorted row; even window takes the floor of the mean
   always_comb begin
      logic signed [KEY_BITS:0] pair;
      if ((WINDOW % 2) != 0) begin
         pair    = {cell_key[WINDOW/2][KEY_BITS-1], cell_key[WINDOW/2]};
         mid_key = cell_key[WINDOW/2];
      end else begin
         pair    = {cell_key[WINDOW/2-1][KEY_BITS-1], cell_key[WINDOW/2-1]}
                 + {cell_key[WINDOW/2][KEY_BITS-1], cell_key[WINDOW/2]};
         mid_key = key_type'(pair >>> 1);
      end
   end

   assign mad_val = mid_key[SAMPLE_BITS-1:0];
   assign lhs     = {dev_ff, 8'b0};
   assign outlier = PROD_BITS'(lhs) > prod_ff;

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      fill_in         = fill_ff;
      pass_in         = pass_ff;
      x_in            = x_ff;
      med_in          = med_ff;
      dev_in          = dev_ff;
      base_in         = base_ff;
      prod_in         = prod_ff;
      scale_in        = scale_ff;
      floor_in        = floor_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_filtered_in = rsp_filtered_ff;
      rsp_replaced_in = rsp_replaced_ff;
      rsp_full_in     = rsp_full_ff;

      if (csr_xfer) begin
         case (csr_index)
            CSR_LIMIT_SCALE: scale_in = csr_data;
            CSR_MAD_FLOOR:   floor_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_xfer) begin
               x_in = sample;
               if (fill_ff < CNT_BITS'(WINDOW)) begin
                  fill_in  = fill_ff + 1'b1;
                  pass_in  = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  pass_in  = 1'b0;
                  state_in = S_SORT_VAL;
               end
            end
         end
         S_SORT_VAL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_BITS'(SORT_STEPS - 1)) begin
               state_in = S_TAKE_MED;
            end
         end
         S_TAKE_MED: begin
            med_in   = sample_type'(mid_key[SAMPLE_BITS-1:0]);
            cnt_in   = '0;
            state_in = S_SORT_DEV;
         end
         S_SORT_DEV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_BITS'(SORT_STEPS - 1)) begin
               state_in = S_TAKE_MAD;
            end
         end
         S_TAKE_MAD: begin
            dev_in   = abs_diff(x_ff, med_ff);
            base_in  = (BASE_BITS'(mad_val) < BASE_BITS'(floor_ff)) ?
                       BASE_BITS'(floor_ff) : BASE_BITS'(mad_val);
            state_in = S_PRODUCT;
         end
         S_PRODUCT: begin
            prod_in  = PROD_BITS'(scale_ff) * PROD_BITS'(base_ff);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pass_ff) begin
                  rsp_filtered_in = x_ff;
                  rsp_replaced_in = 1'b0;
                  rsp_full_in     = 1'b0;
               end else begin
                  rsp_filtered_in = outlier ? med_ff : x_ff;
                  rsp_replaced_in = outlier;
                  rsp_full_in     = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         pass_ff      <= 1'b0;
         scale_ff     <= LIMIT_SCALE_RESET;
         floor_ff     <= MAD_FLOOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         pass_ff      <= pass_in;
         scale_ff     <= scale_in;
         floor_ff     <= floor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      x_ff            <= x_in;
      med_ff          <= med_in;
      dev_ff          <= dev_in;
      base_ff         <= base_in;
      prod_ff         <= prod_in;
      rsp_filtered_ff <= rsp_filtered_in;
      rsp_replaced_ff <= rsp_replaced_in;
      rsp_full_ff     <= rsp_full_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'(rsp_filtered_ff);
   assign rsp_tuser  = {rsp_full_ff, rsp_replaced_ff};

endmodule

`default_nettype wire
